// ===== rtl/sgm_path_cost_aggregation_macros.svh =====
// Assertion macros for the checker of the path cost aggregation block.
`ifndef SGM_PATH_COST_AGGREGATION_MACROS_SVH
`define SGM_PATH_COST_AGGREGATION_MACROS_SVH

// Concurrent assertion on clk, switched off while rst is high.
`define SGMPCA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sgmpca assertion failed");

// Concurrent assertion on clk that also holds across reset.
`define SGMPCA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sgmpca assertion failed during or after reset");

`endif

// ===== rtl/sgmpca_pkg.sv =====
// Package of the path cost aggregation block: constants, register indexes and FSM type.
package sgmpca_pkg;

  localparam int MAX_DISPARITIES_DEFAULT = 64;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PENALTY_SMALL      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PENALTY_LARGE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPARITIES_IN_USE = 2'd2;

  localparam logic [15:0] PENALTY_SMALL_RESET      = 16'd10;
  localparam logic [15:0] PENALTY_LARGE_RESET      = 16'd200;
  localparam logic [6:0]  DISPARITIES_IN_USE_RESET = 7'd64;

  localparam int DIV_STEPS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_CALC,
    ST_OUT
  } sgmpca_state_t;

endpackage

// ===== rtl/sgm_path_cost_aggregation.sv =====
// Semi-global matching path cost aggregation along one path, one disparity per transfer.
// Each accepted item runs one at a time through read, compute and write-back of a two-bank
// path cost memory (one bank holds the previous pixel, the other takes the current one).
// An item that follows the previous disparity of the same pixel reads only one new entry of the
// previous pixel; any other disparity above 0 fetches three entries over the single read port.
// Disparity 0 of each pixel also runs the 16-step radix-2 divider for the large penalty, and
// its item stays in the compute state until the divider is done. A finished result waits in
// the output register while the next item is already accepted. The memory needs no clearing
// after reset.
module sgm_path_cost_aggregation #(
  parameter int MAX_DISPARITIES = sgmpca_pkg::MAX_DISPARITIES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic [sgmpca_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sgmpca_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // match_cost[7:0], pixel_intensity[15:8]
  input  logic                               s_tuser,   // path_start
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,   // path_cost[15:0]
  output logic                               m_tlast    // pixel_done
);

  localparam int DW    = $clog2(MAX_DISPARITIES);
  localparam int AW    = $clog2(2 * MAX_DISPARITIES);
  localparam int DEPTH = 2 * MAX_DISPARITIES;
  localparam int NW    = (DW + 1 > 7) ? DW + 1 : 7;
  localparam int TW    = DW + 2;

  // Configuration registers.
  logic [15:0] penalty_small;
  logic [15:0] penalty_large;
  logic [6:0]  disparities_in_use;

  sgmpca_pkg::sgmpca_state_t state, state_next;

  // Item being worked on.
  logic [7:0]    cost_q;
  logic          start_q;
  logic [DW-1:0] d_q;
  logic          last_q;
  logic [7:0]    inten_hold;

  // Path state.
  logic [7:0]    prev_intensity;
  logic [15:0]   prev_min;
  logic [15:0]   run_min;
  logic [15:0]   p2_eff;
  logic          bank_sel;
  logic [DW-1:0] disp_cnt;

  // Window of previous-pixel costs around the current disparity.
  logic [15:0]   win [3];
  logic          win_valid;
  logic [DW-1:0] win_d;

  logic [1:0]    rd_k;
  logic [1:0]    rd_k_q;
  logic          rd_pend;
  logic [15:0]   mem_q;
  logic [15:0]   bank_mem [DEPTH];

  logic [16:0]   best_q;

  // Divider for the large penalty.
  logic          div_busy;
  logic [3:0]    div_cnt;
  logic [8:0]    div_rem;
  logic [15:0]   div_quo;
  logic [8:0]    div_den;

  logic          s_accept;
  logic          load_out;
  logic [NW-1:0] n_ext;
  logic [DW-1:0] n_m1;
  logic [DW-1:0] d_in;
  logic          fast;
  logic [7:0]    inten_in;
  logic [7:0]    diff_in;
  logic [TW-1:0] tgt;
  logic [TW-1:0] idx_raw;
  logic [DW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [16:0]   c_mid, c_big, c_lo, c_hi, best_a, best_b, best;
  logic [16:0]   minp_ext;
  logic [16:0]   gap;
  logic [17:0]   sum_up;
  logic [15:0]   res;
  logic [15:0]   rmin_new;
  logic [9:0]    div_shift;
  logic          div_ge;
  logic [8:0]    div_rem_next;
  logic [15:0]   div_quo_next;
  logic [16:0]   p1_scaled;
  logic [15:0]   p1_sat;
  logic [15:0]   p2_eff_next;

  // Disparity count in use, clamped to 2..MAX_DISPARITIES.
  always_comb begin
    n_ext = NW'(disparities_in_use);
    if (n_ext < NW'(2)) begin
      n_ext = NW'(2);
    end else if (n_ext > NW'(MAX_DISPARITIES)) begin
      n_ext = NW'(MAX_DISPARITIES);
    end
  end

  assign n_m1     = DW'(n_ext - NW'(1));
  assign d_in     = (disp_cnt > n_m1) ? n_m1 : disp_cnt;
  assign fast     = win_valid && ({1'b0, d_in} == ({1'b0, win_d} + (DW + 1)'(1)));
  assign inten_in = s_tdata[15:8];
  assign diff_in  = (inten_in > prev_intensity) ? inten_in - prev_intensity
                                                : prev_intensity - inten_in;

  assign s_accept = s_tvalid && s_tready;
  assign load_out = (state == sgmpca_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // Read address: entry d-1+k of the previous bank; out-of-range taps read entry 0.
  always_comb begin
    tgt     = TW'(d_q) + TW'(rd_k);
    idx_raw = (tgt == '0) ? '0 : tgt - TW'(1);
    rd_idx  = (idx_raw > TW'(MAX_DISPARITIES - 1)) ? '0 : DW'(idx_raw);
    rd_addr = bank_sel ? AW'(rd_idx) : AW'(rd_idx) + AW'(MAX_DISPARITIES);
    wr_addr = bank_sel ? AW'(d_q) + AW'(MAX_DISPARITIES) : AW'(d_q);
  end

  // Minimum of the four transition candidates.
  always_comb begin
    c_mid  = {1'b0, win[1]};
    c_big  = {1'b0, prev_min} + {1'b0, p2_eff};
    c_lo   = (d_q != '0) ? {1'b0, win[0]} + {1'b0, penalty_small} : '1;
    c_hi   = !last_q ? {1'b0, win[2]} + {1'b0, penalty_small} : '1;
    best_a = (c_mid < c_big) ? c_mid : c_big;
    best_b = (c_lo < c_hi) ? c_lo : c_hi;
    best   = (best_a < best_b) ? best_a : best_b;
  end

  // Path cost from the registered minimum, saturated at 16 bits; a path start passes the cost through.
  always_comb begin
    minp_ext = {1'b0, prev_min};
    gap      = '0;
    sum_up   = '0;
    if (start_q) begin
      res = {8'd0, cost_q};
    end else if (best_q >= minp_ext) begin
      sum_up = 18'(cost_q) + 18'(best_q - minp_ext);
      res    = (sum_up > 18'hFFFF) ? 16'hFFFF : sum_up[15:0];
    end else begin
      gap = minp_ext - best_q;
      res = (17'(cost_q) > gap) ? 16'(17'(cost_q) - gap) : 16'd0;
    end
    rmin_new = (res < run_min) ? res : run_min;
  end

  // One quotient bit per step; the last step also forms the effective large penalty.
  always_comb begin
    div_shift    = {div_rem, div_quo[15]};
    div_ge       = div_shift >= {1'b0, div_den};
    div_rem_next = div_ge ? 9'(div_shift - {1'b0, div_den}) : div_shift[8:0];
    div_quo_next = {div_quo[14:0], div_ge};
    p1_scaled    = {1'b0, penalty_small} + {2'b0, penalty_small[15:1]};
    p1_sat       = p1_scaled[16] ? 16'hFFFF : p1_scaled[15:0];
    p2_eff_next  = (p1_sat > div_quo_next) ? p1_sat : div_quo_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      sgmpca_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = sgmpca_pkg::ST_READ;
        end
      end
      sgmpca_pkg::ST_READ: begin
        if (rd_k == 2'd2) begin
          state_next = sgmpca_pkg::ST_WAIT;
        end
      end
      sgmpca_pkg::ST_WAIT: begin
        state_next = sgmpca_pkg::ST_CALC;
      end
      sgmpca_pkg::ST_CALC: begin
        if (!div_busy) begin
          state_next = sgmpca_pkg::ST_OUT;
        end
      end
      sgmpca_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = sgmpca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sgmpca_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgmpca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_small      <= sgmpca_pkg::PENALTY_SMALL_RESET;
      penalty_large      <= sgmpca_pkg::PENALTY_LARGE_RESET;
      disparities_in_use <= sgmpca_pkg::DISPARITIES_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgmpca_pkg::REG_PENALTY_SMALL:      penalty_small      <= cfg_data;
        sgmpca_pkg::REG_PENALTY_LARGE:      penalty_large      <= cfg_data;
        sgmpca_pkg::REG_DISPARITIES_IN_USE: disparities_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Path memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (load_out) begin
      bank_mem[wr_addr] <= res;
    end
    mem_q <= bank_mem[rd_addr];
  end

  // Item registers and window.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cost_q  <= s_tdata[7:0];
      start_q <= s_tuser;
      d_q     <= d_in;
      last_q  <= (d_in == n_m1);
      win_d   <= d_in;
      if (fast) begin
        win[0] <= win[1];
        win[1] <= win[2];
      end
    end
    if (rd_pend) begin
      win[rd_k_q] <= mem_q;
    end
    if (state == sgmpca_pkg::ST_CALC) begin
      best_q <= best;
    end
    rd_k_q <= rd_k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_k      <= '0;
      rd_pend   <= 1'b0;
      win_valid <= 1'b0;
    end else begin
      rd_pend <= (state == sgmpca_pkg::ST_READ);
      if (s_accept) begin
        rd_k      <= fast ? 2'd2 : 2'd0;
        win_valid <= 1'b1;
      end else if (state == sgmpca_pkg::ST_READ && rd_k != 2'd2) begin
        rd_k <= rd_k + 2'd1;
      end
      // The window belongs to the previous pixel and is stale once the banks swap.
      if (load_out && last_q) begin
        win_valid <= 1'b0;
      end
    end
  end

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (s_accept && d_in == '0) begin
      div_rem <= '0;
      div_quo <= penalty_large;
      div_den <= {1'b0, diff_in} + 9'd1;
    end else if (div_busy) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
      p2_eff   <= '0;
    end else if (s_accept && d_in == '0) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 4'd1;
      if (div_cnt == 4'(sgmpca_pkg::DIV_STEPS - 1)) begin
        div_busy <= 1'b0;
        p2_eff   <= p2_eff_next;
      end
    end
  end

  // Path state update when a result is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_intensity <= '0;
      prev_min       <= '0;
      run_min        <= '1;
      bank_sel       <= 1'b0;
      disp_cnt       <= '0;
    end else begin
      if (s_accept) begin
        disp_cnt <= d_in;
      end
      if (load_out) begin
        if (last_q) begin
          prev_min       <= rmin_new;
          run_min        <= '1;
          prev_intensity <= inten_hold;
          bank_sel       <= !bank_sel;
          disp_cnt       <= '0;
        end else begin
          run_min  <= rmin_new;
          disp_cnt <= d_q + DW'(1);
        end
      end
    end
  end

  // Intensity of the item in flight, taken into the path state on its last disparity.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      inten_hold <= inten_in;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res;
      m_tlast <= last_q;
    end
  end

endmodule

// ===== rtl/sgmpca_checker.sv =====
// Port-level checker for the path cost aggregation block, bound to its top level.
`include "sgm_path_cost_aggregation_macros.svh"

module sgmpca_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // Reset leaves no result pending.
  `SGMPCA_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid)

  // A stalled result holds its payload.
  `SGMPCA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Items are worked one at a time: after a transfer in, the input side closes.
  `SGMPCA_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready)

  // A result waits for its memory reads; it never appears right after a transfer in.
  `SGMPCA_ASSERT(a_min_latency, s_tvalid && s_tready |=> !$rose(m_tvalid))

endmodule

bind sgm_path_cost_aggregation sgmpca_checker u_sgmpca_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/tb_sgm_path_cost_aggregation.sv =====
// Testbench of the SGM path cost aggregation block: directed table, then random pixel streams.
`timescale 1ns / 1ps

module tb_sgm_path_cost_aggregation;

  localparam int          MAXD           = sgmpca_pkg::MAX_DISPARITIES_DEFAULT;
  localparam int          IW             = sgmpca_pkg::CFG_INDEX_W;
  localparam int unsigned ITEMS_TARGET   = 2000;
  localparam int unsigned CALM_ITEMS     = 200;
  localparam int unsigned RAMP_PIXELS    = 280;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RUN_LIMIT_NS   = 6_000_000;
  localparam logic [IW-1:0] REG_UNUSED = 2'd3;
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [IW-1:0]           idx;
    logic [15:0]             val;
    logic [7:0]              cost;
    logic [7:0]              inten;
    bit                      start;
    bit                      typed;
    logic [15:0]             exp_cost;
    bit                      exp_last;
  } plan_row_t;

  typedef struct packed {
    logic [15:0] cost;
    logic        last;
  } cost_result_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_wr_en;
  logic [IW-1:0]                       cfg_index;
  logic [sgmpca_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [15:0]                         s_tdata;   // match_cost[7:0], pixel_intensity[15:8]
  logic                                s_tuser;   // path_start
  logic                                m_tvalid;
  logic                                m_tready;
  logic [15:0]                         m_tdata;   // path_cost[15:0]
  logic                                m_tlast;   // pixel_done

  sgm_path_cost_aggregation #(.MAX_DISPARITIES(MAXD)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Predictor state of the aggregation path.
  logic [15:0]  p1_reg;
  logic [15:0]  p2_reg;
  logic [6:0]   ndisp_reg;
  logic [15:0]  cost_bank [0:2*MAXD-1];
  bit           bank_written [0:2*MAXD-1];
  int unsigned  prev_min;
  int unsigned  run_min;
  int unsigned  prev_inten;
  int unsigned  p2_eff;
  int unsigned  disp_cnt;
  bit           bank_sel;

  cost_result_t pending_costs [$];
  plan_row_t    plan [$];
  int unsigned  items_sent;
  int unsigned  mismatches;
  int unsigned  src_gap_pct;
  int unsigned  sink_stall_pct;
  bit           calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned lesser(input int unsigned a, input int unsigned b);
    lesser = (a < b) ? a : b;
  endfunction

  function automatic int unsigned active_count();
    if (ndisp_reg < 2) active_count = 2;
    else if (ndisp_reg > MAXD) active_count = MAXD;
    else active_count = ndisp_reg;
  endfunction

  function automatic int unsigned current_disp();
    int unsigned n;
    n = active_count();
    current_disp = (disp_cnt > n - 1) ? n - 1 : disp_cnt;
  endfunction

  function automatic int unsigned pixel_remaining();
    pixel_remaining = active_count() - current_disp();
  endfunction

  // A non-start item reads its neighbors in the previous bank; all of them must hold data.
  function automatic bit start_needed();
    int unsigned n, d, rd;
    n  = active_count();
    d  = current_disp();
    rd = bank_sel ? 0 : MAXD;
    start_needed = !bank_written[rd + d] ||
                   (d > 0 && !bank_written[rd + d - 1]) ||
                   (d != n - 1 && !bank_written[rd + d + 1]);
  endfunction

  function automatic cost_result_t aggregate_cost(input logic [7:0] cost,
                                                  input logic [7:0] inten, input bit start);
    cost_result_t r;
    int unsigned  n, d, wr, rd, diff, a, b, m, minp, best, res, c, i;
    bit           last;
    n = active_count();
    if (disp_cnt > n - 1) disp_cnt = n - 1;
    d    = disp_cnt;
    last = (d == n - 1);
    wr   = bank_sel ? MAXD : 0;
    rd   = bank_sel ? 0 : MAXD;
    c    = cost;
    i    = inten;
    if (d == 0) begin
      diff   = (i > prev_inten) ? i - prev_inten : prev_inten - i;
      a      = (int'(p1_reg) * 3) / 2;
      b      = int'(p2_reg) / (diff + 1);
      m      = (a > b) ? a : b;
      p2_eff = (m > 16'hFFFF) ? 16'hFFFF : m;
    end
    if (start) begin
      res = c;
    end else begin
      minp = prev_min;
      best = lesser(cost_bank[rd + d], minp + p2_eff);
      if (d > 0) best = lesser(best, int'(cost_bank[rd + d - 1]) + int'(p1_reg));
      if (!last) best = lesser(best, int'(cost_bank[rd + d + 1]) + int'(p1_reg));
      if (best >= minp) res = c + (best - minp);
      else res = (c > minp - best) ? c - (minp - best) : 0;
      if (res > 16'hFFFF) res = 16'hFFFF;
    end
    cost_bank[wr + d]    = res[15:0];
    bank_written[wr + d] = 1'b1;
    if (res < run_min) run_min = res;
    if (last) begin
      prev_min   = run_min;
      run_min    = 16'hFFFF;
      prev_inten = i;
      bank_sel   = ~bank_sel;
      disp_cnt   = 0;
    end else begin
      disp_cnt = d + 1;
    end
    r.cost = res[15:0];
    r.last = last;
    aggregate_cost = r;
  endfunction

  function automatic void plan_cfg(input logic [IW-1:0] idx, input logic [15:0] val);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    plan = {plan, row};
  endfunction

  function automatic void plan_item(input logic [7:0] cost, input logic [7:0] inten,
                                    input bit start, input bit typed,
                                    input logic [15:0] exp_cost, input bit exp_last);
    plan_row_t row;
    row          = '0;
    row.kind     = ROW_ITEM;
    row.cost     = cost;
    row.inten    = inten;
    row.start    = start;
    row.typed    = typed;
    row.exp_cost = exp_cost;
    row.exp_last = exp_last;
    plan = {plan, row};
  endfunction

  // Lowers the input valid and waits until every result is back, so a register can change.
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (pending_costs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      sgmpca_pkg::REG_PENALTY_SMALL: p1_reg = val;
      sgmpca_pkg::REG_PENALTY_LARGE: p2_reg = val;
      sgmpca_pkg::REG_DISPARITIES_IN_USE: begin
        ndisp_reg = val[6:0];
        // Bank contents from before a count change are off limits.
        foreach (bank_written[k]) bank_written[k] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [7:0] cost, input logic [7:0] inten, input bit start,
                           input bit typed, input logic [15:0] exp_cost, input bit exp_last);
    cost_result_t r;
    bit           s;
    if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s = start;
    if (!s && start_needed()) s = 1'b1;
    s_tvalid <= 1'b1;
    s_tdata  <= {inten, cost};
    s_tuser  <= s;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = aggregate_cost(cost, inten, s);
    if (typed) begin
      r.cost = exp_cost;
      r.last = exp_last;
    end
    pending_costs = {pending_costs, r};
    items_sent++;
    if (items_sent >= ITEMS_TARGET - CALM_ITEMS) calm = 1'b1;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cost_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transfer: path_cost %0d pixel_done %0b", m_tdata, m_tlast);
      end else begin
        want = pending_costs.pop_front();
        if (m_tdata !== want.cost || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected path_cost %0d pixel_done %0b, got %0d %0b",
                     want.cost, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned phase, pixels, left, n;
    bit          new_path, cut;
    logic [7:0]  inten, cost, item_inten;
    logic [6:0]  disp_val;
    logic [15:0] pval;

    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = 1'b0;
    items_sent     = 0;
    mismatches     = 0;
    calm           = 1'b0;
    src_gap_pct    = 25;
    sink_stall_pct = 25;
    p1_reg         = sgmpca_pkg::PENALTY_SMALL_RESET;
    p2_reg         = sgmpca_pkg::PENALTY_LARGE_RESET;
    ndisp_reg      = sgmpca_pkg::DISPARITIES_IN_USE_RESET;
    prev_min       = 0;
    run_min        = 16'hFFFF;
    prev_inten     = 0;
    p2_eff         = 0;
    disp_cnt       = 0;
    bank_sel       = 1'b0;
    inten          = '0;
    foreach (cost_bank[k]) begin
      cost_bank[k]    = '0;
      bank_written[k] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Path start passes costs through; then a full pixel with extreme costs and intensities.
    plan_cfg(sgmpca_pkg::REG_DISPARITIES_IN_USE, 16'd3);
    plan_item(8'd0,   8'd0,   1'b1, TYPED, 16'd0,   1'b0);
    plan_item(8'd255, 8'd0,   1'b1, TYPED, 16'd255, 1'b0);
    plan_item(8'd7,   8'd0,   1'b1, TYPED, 16'd7,   1'b1);
    plan_item(8'd255, 8'd255, 1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd0,   8'd255, 1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd128, 8'd255, 1'b0, PREDICTED, 16'd0, 1'b0);
    // Start flag on the first disparity only.
    plan_item(8'd10,  8'd128, 1'b1, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd20,  8'd128, 1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd30,  8'd128, 1'b0, PREDICTED, 16'd0, 1'b0);
    // Largest penalties: the scaled small penalty saturates.
    plan_cfg(sgmpca_pkg::REG_PENALTY_SMALL, 16'hFFFF);
    plan_cfg(sgmpca_pkg::REG_PENALTY_LARGE, 16'hFFFF);
    plan_item(8'd1,   8'd128, 1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd255, 8'd128, 1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd0,   8'd128, 1'b0, PREDICTED, 16'd0, 1'b0);
    // With both penalties zero the best term equals the previous minimum.
    plan_cfg(sgmpca_pkg::REG_PENALTY_SMALL, 16'd0);
    plan_cfg(sgmpca_pkg::REG_PENALTY_LARGE, 16'd0);
    plan_item(8'd255, 8'd0,   1'b0, TYPED, 16'd255, 1'b0);
    plan_item(8'd0,   8'd0,   1'b0, TYPED, 16'd0,   1'b0);
    plan_item(8'd255, 8'd0,   1'b0, TYPED, 16'd255, 1'b1);
    plan_cfg(sgmpca_pkg::REG_PENALTY_SMALL, 16'd10);
    plan_cfg(sgmpca_pkg::REG_PENALTY_LARGE, 16'd200);
    // The count shrinks mid-pixel, so the next item closes the pixel.
    plan_item(8'd5,   8'd7,   1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd6,   8'd7,   1'b0, PREDICTED, 16'd0, 1'b0);
    plan_cfg(sgmpca_pkg::REG_DISPARITIES_IN_USE, 16'd2);
    plan_item(8'd9,   8'd7,   1'b1, TYPED, 16'd9,   1'b1);
    // A count below the minimum acts as two.
    plan_cfg(sgmpca_pkg::REG_DISPARITIES_IN_USE, 16'd1);
    plan_item(8'd3,   8'd50,  1'b1, TYPED, 16'd3,   1'b0);
    plan_item(8'd4,   8'd50,  1'b1, TYPED, 16'd4,   1'b1);
    plan_item(8'd0,   8'd60,  1'b0, PREDICTED, 16'd0, 1'b0);
    plan_item(8'd255, 8'd60,  1'b0, PREDICTED, 16'd0, 1'b0);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain_block();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        push_item(plan[k].cost, plan[k].inten, plan[k].start,
                  plan[k].typed, plan[k].exp_cost, plan[k].exp_last);
      end
    end

    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      drain_block();
      if (phase == 0) begin
        // One disparity stays cheap, the other grows by almost 255 per pixel until it saturates.
        write_reg(sgmpca_pkg::REG_DISPARITIES_IN_USE, 16'd2);
        write_reg(sgmpca_pkg::REG_PENALTY_SMALL, 16'hFFFF);
        write_reg(sgmpca_pkg::REG_PENALTY_LARGE, 16'hFFFF);
        src_gap_pct    = 10;
        sink_stall_pct = 10;
        for (int px = 0; px < RAMP_PIXELS; px++) begin
          inten = 8'($urandom_range(0, 255));
          push_item(8'($urandom_range(0, 3)), inten, 1'b0, PREDICTED, 16'd0, 1'b0);
          push_item(8'($urandom_range(252, 255)), inten, 1'b0, PREDICTED, 16'd0, 1'b0);
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 11))
            0: disp_val = 7'd2;
            1: disp_val = 7'd64;
            2: disp_val = 7'd0;
            3: disp_val = 7'd1;
            4: disp_val = 7'd127;
            5: disp_val = 7'($urandom_range(2, 64));
            default: disp_val = 7'($urandom_range(3, 10));
          endcase
          write_reg(sgmpca_pkg::REG_DISPARITIES_IN_USE, {9'd0, disp_val});
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0: pval = 16'd0;
            1: pval = 16'hFFFF;
            2: pval = 16'($urandom_range(0, 65535));
            default: pval = 16'($urandom_range(0, 40));
          endcase
          write_reg(sgmpca_pkg::REG_PENALTY_SMALL, pval);
        end
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0: pval = 16'd0;
            1: pval = 16'hFFFF;
            2: pval = 16'($urandom_range(0, 65535));
            default: pval = 16'($urandom_range(0, 400));
          endcase
          write_reg(sgmpca_pkg::REG_PENALTY_LARGE, pval);
        end
        if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        src_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        n      = active_count();
        pixels = (160 / n < 2) ? 2 : 160 / n;
        cut    = ($urandom_range(0, 3) == 0);
        for (int px = 0; px < pixels; px++) begin
          new_path = ($urandom_range(0, 7) == 0);
          case ($urandom_range(0, 5))
            0: ;
            1: inten = 8'd0;
            2: inten = 8'd255;
            default: inten = 8'($urandom_range(0, 255));
          endcase
          left = pixel_remaining();
          // Leaving the last pixel unfinished lets the next settings land mid-pixel.
          if (cut && px == pixels - 1 && left > 1) left = $urandom_range(1, left - 1);
          for (int k = 0; k < left; k++) begin
            case ($urandom_range(0, 9))
              0: cost = 8'd255;
              1: cost = 8'd0;
              default: cost = 8'($urandom_range(0, 255));
            endcase
            item_inten = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : inten;
            push_item(cost, item_inten, new_path ^ ($urandom_range(0, 19) == 0),
                      PREDICTED, 16'd0, 1'b0);
          end
        end
      end
      phase++;
    end

    drain_block();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
